@@ design/gbc_pkg.sv @@
// Shared types and constants of the Gaussian naive Bayes classifier.
package gbc_pkg;

    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int BIAS_W   = 32;
    localparam int LABEL_W  = 16;
    localparam int ACC_W    = 48;
    localparam int PROD_W   = 48;
    localparam int SCORE_W  = 50;
    localparam int ROUND_SHIFT = 12;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_TABLE  = 2'd0,
        FUNC_BIAS   = 2'd1,
        FUNC_SAMPLE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MAC_HOLD   = 2'd0,
        MAC_DIFF   = 2'd1,
        MAC_SQUARE = 2'd2,
        MAC_WEIGHT = 2'd3
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
    } mac_ctrl_t;

endpackage

@@ design/gbc_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module gbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/gbc_mac.sv @@
// Shared distance unit: difference, one multiplier used twice, rounding and saturating add.
module gbc_mac (
    input  logic                           aclk,
    input  gbc_pkg::mac_ctrl_t             ctrl,
    input  logic [gbc_pkg::VALUE_W-1:0]    sample,
    input  logic [gbc_pkg::VALUE_W-1:0]    mean,
    input  logic [gbc_pkg::WEIGHT_W-1:0]   weight,
    input  logic [gbc_pkg::ACC_W-1:0]      acc_in,
    output logic [gbc_pkg::ACC_W-1:0]      acc_out
);

    logic [gbc_pkg::VALUE_W-1:0]  ad_reg;
    logic [gbc_pkg::WEIGHT_W-1:0] w_reg;
    logic [gbc_pkg::PROD_W-1:0]   prod_reg;

    logic signed [gbc_pkg::VALUE_W:0] diff;
    logic [gbc_pkg::VALUE_W:0]        abs_diff;
    logic [31:0]                      mul_a;
    logic [15:0]                      mul_b;
    logic [gbc_pkg::PROD_W-1:0]       mul_p;
    logic [gbc_pkg::PROD_W:0]         rounded;
    logic [gbc_pkg::ACC_W:0]          sum;

    assign diff = $signed({sample[gbc_pkg::VALUE_W-1], sample})
                - $signed({mean[gbc_pkg::VALUE_W-1], mean});
    assign abs_diff = diff[gbc_pkg::VALUE_W] ? (gbc_pkg::VALUE_W+1)'(-diff)
                                             : (gbc_pkg::VALUE_W+1)'(diff);

    // The same multiplier first squares the difference, then scales by the weight.
    always_comb begin
        case (ctrl.op)
            gbc_pkg::MAC_SQUARE: begin
                mul_a = 32'(ad_reg);
                mul_b = 16'(ad_reg);
            end
            gbc_pkg::MAC_WEIGHT: begin
                mul_a = prod_reg[31:0];
                mul_b = 16'(w_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = gbc_pkg::PROD_W'(mul_a) * gbc_pkg::PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            gbc_pkg::MAC_DIFF: begin
                ad_reg <= abs_diff[gbc_pkg::VALUE_W-1:0];
                w_reg  <= weight;
            end
            gbc_pkg::MAC_SQUARE: begin
                prod_reg <= mul_p;
            end
            gbc_pkg::MAC_WEIGHT: begin
                prod_reg <= mul_p;
            end
            default: begin
            end
        endcase
    end

    // Round half up from Q.28 to Q.16, then add with saturation.
    assign rounded = ({1'b0, prod_reg} + (gbc_pkg::PROD_W+1)'(2048))
                     >> gbc_pkg::ROUND_SHIFT;
    assign sum = {1'b0, acc_in} + rounded[gbc_pkg::ACC_W:0];
    assign acc_out = sum[gbc_pkg::ACC_W] ? gbc_pkg::ACC_MAX : sum[gbc_pkg::ACC_W-1:0];

endmodule

@@ design/gaussian_bayes_classifier.sv @@
// Top level of the Gaussian naive Bayes classifier: sequencer, class tables and decision.
//
// Input items arrive on s_tvalid/s_tready; tuser carries the function code.
// A table item (mean and weight, or bias and label) is stored when it is accepted.
// A feature sample item visits each class in use with one shared multiplier:
// a read step, then per class the difference, square, weight and accumulate
// steps, with s_tready held low throughout; N is the class count. A sample
// marked by tlast then scans the N class scores, one per cycle, then the
// emit step loads the result register; all accumulators clear at the end of
// the scan. The result item (label, class index and saturated score) waits
// on m_tvalid until m_tready takes it; the block keeps accepting items
// meanwhile and only holds a later decision until the result register is
// free. The user must write classes_in_use through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
// Reset (aresetn low, synchronous) clears the accumulators, drops m_tvalid
// and sets the class count to one; the tables hold unknown data until
// written.
module gaussian_bayes_classifier #(
    parameter int MAX_CLASSES  = 16,
    parameter int MAX_FEATURES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: class_index[4], feature_index[6], mean_value[16],
    // weight_value[16], bias_value[32], label_value[16], sample_value[16], pad
    input  logic [111:0] s_tdata,
    // tuser: func[2]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: predicted_label[16], winning_class[4], winning_score[32], pad
    output logic [55:0]  m_tdata
);

    localparam int TBL_DEPTH = MAX_CLASSES * MAX_FEATURES;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CLS_W     = $clog2(MAX_CLASSES);
    localparam int CNT_W     = $clog2(MAX_CLASSES + 1);
    localparam int TBL_W     = gbc_pkg::VALUE_W + gbc_pkg::WEIGHT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQUARE,
        ST_WEIGHT,
        ST_ACCUM,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [3:0]  s_class;
    logic [5:0]  s_feat;
    logic [15:0] s_mean;
    logic [15:0] s_weight;
    logic [31:0] s_bias;
    logic [15:0] s_label;
    logic [15:0] s_sample;

    assign s_class  = s_tdata[3:0];
    assign s_feat   = s_tdata[9:4];
    assign s_mean   = s_tdata[25:10];
    assign s_weight = s_tdata[41:26];
    assign s_bias   = s_tdata[73:42];
    assign s_label  = s_tdata[89:74];
    assign s_sample = s_tdata[105:90];

    logic [4:0]                        classes_in_use_reg;
    logic [CLS_W-1:0]                  cls_reg;
    logic [5:0]                        feat_reg;
    logic [gbc_pkg::VALUE_W-1:0]       x_reg;
    logic                              last_reg;
    logic [gbc_pkg::ACC_W-1:0]         acc_reg [MAX_CLASSES];
    logic [gbc_pkg::BIAS_W-1:0]        bias_reg [MAX_CLASSES];
    logic [gbc_pkg::LABEL_W-1:0]       label_reg [MAX_CLASSES];
    logic signed [gbc_pkg::SCORE_W-1:0] best_reg;
    logic [CLS_W-1:0]                  best_idx_reg;
    logic                              m_tvalid_reg;
    logic [55:0]                       m_tdata_reg;

    logic [CNT_W-1:0]                  n_active;
    logic                              cls_is_last;
    logic                              accept;
    logic                              s_cls_ok;
    logic                              s_feat_ok;
    logic [CLS_W-1:0]                  rd_cls;
    logic [TBL_AW-1:0]                 wr_addr;
    logic [TBL_AW-1:0]                 rd_addr;
    logic [TBL_W-1:0]                  tbl_rdata;
    logic                              tbl_wr_en;
    gbc_pkg::mac_ctrl_t                mac_ctrl;
    logic [gbc_pkg::ACC_W-1:0]         mac_acc;
    logic signed [gbc_pkg::SCORE_W-1:0] score;
    logic [31:0]                       sat_score;

    // A count of zero means one class; larger counts clip to the table size.
    always_comb begin
        if (classes_in_use_reg == 5'd0) begin
            n_active = CNT_W'(1);
        end else if (32'(classes_in_use_reg) > MAX_CLASSES) begin
            n_active = CNT_W'(MAX_CLASSES);
        end else begin
            n_active = CNT_W'(classes_in_use_reg);
        end
    end

    assign cls_is_last = (CNT_W'(cls_reg) == n_active - CNT_W'(1));
    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_cls_ok    = (32'(s_class) < MAX_CLASSES);
    assign s_feat_ok   = (32'(s_feat) < MAX_FEATURES);

    assign tbl_wr_en = accept && (s_tuser == gbc_pkg::FUNC_TABLE) && s_cls_ok && s_feat_ok;
    assign wr_addr   = TBL_AW'(32'(s_class) * MAX_FEATURES + 32'(s_feat));
    // The accumulate step already fetches the next class's entry.
    assign rd_cls    = (state_reg == ST_ACCUM) ? cls_reg + CLS_W'(1) : cls_reg;
    assign rd_addr   = TBL_AW'(32'(rd_cls) * MAX_FEATURES + 32'(feat_reg));

    gbc_ram #(
        .WIDTH (TBL_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (wr_addr),
        .wr_data ({s_mean, s_weight}),
        .rd_addr (rd_addr),
        .rd_data (tbl_rdata)
    );

    always_comb begin
        case (state_reg)
            ST_DIFF:   mac_ctrl.op = gbc_pkg::MAC_DIFF;
            ST_SQUARE: mac_ctrl.op = gbc_pkg::MAC_SQUARE;
            ST_WEIGHT: mac_ctrl.op = gbc_pkg::MAC_WEIGHT;
            default:   mac_ctrl.op = gbc_pkg::MAC_HOLD;
        endcase
    end

    gbc_mac u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .sample  (x_reg),
        .mean    (tbl_rdata[TBL_W-1:gbc_pkg::WEIGHT_W]),
        .weight  (tbl_rdata[gbc_pkg::WEIGHT_W-1:0]),
        .acc_in  (acc_reg[cls_reg]),
        .acc_out (mac_acc)
    );

    assign score = $signed({{(gbc_pkg::SCORE_W-gbc_pkg::BIAS_W){bias_reg[cls_reg][31]}},
                            bias_reg[cls_reg]})
                 - $signed({{(gbc_pkg::SCORE_W-gbc_pkg::ACC_W){1'b0}}, acc_reg[cls_reg]});

    always_comb begin
        if (best_reg > 50'sd2147483647) begin
            sat_score = 32'h7FFF_FFFF;
        end else if (best_reg < -50'sd2147483648) begin
            sat_score = 32'h8000_0000;
        end else begin
            sat_score = best_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            classes_in_use_reg <= 5'd1;
            cls_reg            <= '0;
            m_tvalid_reg       <= 1'b0;
            for (int i = 0; i < MAX_CLASSES; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                classes_in_use_reg <= cfg_wr_data;
            end
            // The emit step reloads the result register itself when it is taken.
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_tuser)
                            gbc_pkg::FUNC_BIAS: begin
                                if (s_cls_ok) begin
                                    bias_reg[CLS_W'(s_class)]  <= s_bias;
                                    label_reg[CLS_W'(s_class)] <= s_label;
                                end
                            end
                            gbc_pkg::FUNC_SAMPLE: begin
                                x_reg    <= s_sample;
                                feat_reg <= s_feat;
                                last_reg <= s_tlast;
                                cls_reg  <= '0;
                                if (s_feat_ok) begin
                                    state_reg <= ST_READ;
                                end else if (s_tlast) begin
                                    state_reg <= ST_DECIDE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    state_reg <= ST_WEIGHT;
                end
                ST_WEIGHT: begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    acc_reg[cls_reg] <= mac_acc;
                    if (cls_is_last) begin
                        cls_reg   <= '0;
                        state_reg <= last_reg ? ST_DECIDE : ST_IDLE;
                    end else begin
                        cls_reg   <= cls_reg + CLS_W'(1);
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DECIDE: begin
                    // Strictly greater keeps the lowest class index on a tie.
                    if (cls_reg == '0 || score > best_reg) begin
                        best_reg     <= score;
                        best_idx_reg <= cls_reg;
                    end
                    if (cls_is_last) begin
                        cls_reg   <= '0;
                        state_reg <= ST_EMIT;
                        for (int i = 0; i < MAX_CLASSES; i++) begin
                            acc_reg[i] <= '0;
                        end
                    end else begin
                        cls_reg <= cls_reg + CLS_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {4'b0, sat_score, 4'(best_idx_reg),
                                         label_reg[best_idx_reg]};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared outside the emit step");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && m_tvalid && !m_tready |=> (state_reg == ST_EMIT))
        else $error("pending result was overwritten");

    a_class_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCUM || state_reg == ST_DECIDE) |-> (CNT_W'(cls_reg) < n_active))
        else $error("class counter ran past the classes in use");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser == gbc_pkg::FUNC_SAMPLE) && s_feat_ok |=> !s_tready)
        else $error("sample accepted without starting the class sweep");

endmodule
